>>> design/triangle_unit_normal_macros.svh
// Assertion macros for the triangle normal top level.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

// same-cycle implication
`define TUN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TUN_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tun_pkg.sv
// Shared constants for the triangle normal pipeline.
// No dependencies.
`default_nettype none
package tun_pkg;
	localparam int OUT_W    = 16;
	localparam int MINLEN_W = 50;
	localparam int AXES     = 3;
endpackage
`default_nettype wire

>>> design/tun_cross.sv
// Edge vectors and exact cross product, three register stages.
// Uses tun_pkg.
`default_nettype none
module tun_cross #(
	parameter int CW = 24,
	parameter int EW = CW + 1,
	parameter int MW = 2 * EW
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_vld,
	input  wire logic signed [CW-1:0] a [tun_pkg::AXES],
	input  wire logic signed [CW-1:0] b [tun_pkg::AXES],
	input  wire logic signed [CW-1:0] c [tun_pkg::AXES],
	output logic                      vld,
	output logic [MW-1:0]             mag [tun_pkg::AXES],
	output logic                      neg [tun_pkg::AXES]
);
	localparam int PW = 2 * EW;

	logic signed [EW-1:0] e1_s1 [tun_pkg::AXES];
	logic signed [EW-1:0] e2_s1 [tun_pkg::AXES];
	logic signed [PW-1:0] p_s2 [tun_pkg::AXES];
	logic signed [PW-1:0] q_s2 [tun_pkg::AXES];
	logic [MW-1:0]        mag_s3 [tun_pkg::AXES];
	logic                 neg_s3 [tun_pkg::AXES];
	logic                 vld_s1, vld_s2, vld_s3;
	logic signed [PW:0]   diff [tun_pkg::AXES];
	logic signed [PW:0]   absd [tun_pkg::AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < tun_pkg::AXES; k++) begin
			diff[k] = $signed({p_s2[k][PW-1], p_s2[k]}) - $signed({q_s2[k][PW-1], q_s2[k]});
			absd[k] = diff[k][PW] ? -diff[k] : diff[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < tun_pkg::AXES; k++) begin
				e1_s1[k] <= $signed({b[k][CW-1], b[k]}) - $signed({a[k][CW-1], a[k]});
				e2_s1[k] <= $signed({c[k][CW-1], c[k]}) - $signed({a[k][CW-1], a[k]});
			end
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			q_s2[0] <= e1_s1[2] * e2_s1[1];
			p_s2[1] <= e1_s1[2] * e2_s1[0];
			q_s2[1] <= e1_s1[0] * e2_s1[2];
			p_s2[2] <= e1_s1[0] * e2_s1[1];
			q_s2[2] <= e1_s1[1] * e2_s1[0];
			for (int k = 0; k < tun_pkg::AXES; k++) begin
				neg_s3[k] <= diff[k][PW];
				mag_s3[k] <= absd[k][MW-1:0];
			end
		end
	end

	assign vld = vld_s3;
	assign mag = mag_s3;
	assign neg = neg_s3;
endmodule
`default_nettype wire

>>> design/tun_square.sv
// Squared length of the cross product from split half-width products.
// Uses tun_pkg.
`default_nettype none
module tun_square #(
	parameter int MW  = 50,
	parameter int SBW = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  wire logic [MW-1:0]    mag [tun_pkg::AXES],
	input  wire logic [SBW-1:0]   side_in,
	output logic                  vld,
	output logic [2*MW+1:0]       sum,
	output logic [SBW-1:0]        side_out
);
	localparam int H  = MW / 2;
	localparam int HW = MW - H;
	localparam int QW = 2 * MW;

	logic [2*HW-1:0] hh_s1 [tun_pkg::AXES];
	logic [2*HW-1:0] hl_s1 [tun_pkg::AXES];
	logic [2*H-1:0]  ll_s1 [tun_pkg::AXES];
	logic [QW-1:0]   sq_s2 [tun_pkg::AXES];
	logic [QW+1:0]   sum_s3;
	logic [SBW-1:0]  side_s1, side_s2, side_s3;
	logic            vld_s1, vld_s2, vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < tun_pkg::AXES; k++) begin
				hh_s1[k] <= mag[k][MW-1:H] * mag[k][MW-1:H];
				hl_s1[k] <= mag[k][MW-1:H] * HW'(mag[k][H-1:0]);
				ll_s1[k] <= mag[k][H-1:0] * mag[k][H-1:0];
				// recombine: hi^2 * 2^2H + hi*lo * 2^(H+1) + lo^2
				sq_s2[k] <= (QW'(hh_s1[k]) << (2 * H)) + (QW'(hl_s1[k]) << (H + 1))
					+ QW'(ll_s1[k]);
			end
			sum_s3  <= (QW+2)'(sq_s2[0]) + (QW+2)'(sq_s2[1]) + (QW+2)'(sq_s2[2]);
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
		end
	end

	assign vld      = vld_s3;
	assign sum      = sum_s3;
	assign side_out = side_s3;
endmodule
`default_nettype wire

>>> design/tun_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Standalone; does not use tun_pkg.
`default_nettype none
module tun_isqrt #(
	parameter int SW  = 102,
	parameter int SBW = 8,
	parameter int N   = SW / 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire logic [SW-1:0]  rad,
	input  wire logic [SBW-1:0] side_in,
	output logic                vld,
	output logic [N-1:0]        root,
	output logic [SBW-1:0]      side_out
);
	localparam int RMW = N + 2;

	logic [RMW-1:0] rem_s  [N+1];
	logic [N-1:0]   root_s [N+1];
	logic [SW-1:0]  rad_s  [N+1];
	logic [SBW-1:0] side_s [N+1];
	logic           vld_s  [N+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_vld;

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [RMW-1:0] cand, trial;
		logic           ge;

		always_comb begin
			// bring down the next two radicand bits, try root*4+1
			cand  = {rem_s[j][RMW-3:0], rad_s[j][SW-1:SW-2]};
			trial = {root_s[j], 2'b01};
			ge    = cand >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? cand - trial : cand;
				root_s[j+1] <= {root_s[j][N-2:0], ge};
				rad_s[j+1]  <= {rad_s[j][SW-3:0], 2'b00};
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign vld      = vld_s[N];
	assign root     = root_s[N];
	assign side_out = side_s[N];
endmodule
`default_nettype wire

>>> design/tun_div.sv
// Three-lane restoring divider: rounded |X.k| * 2^F / L, one quotient bit per stage.
// Uses tun_pkg.
`default_nettype none
module tun_div #(
	parameter int MW = 50,
	parameter int RW = 51,
	parameter int F  = 14,
	parameter int QW = F + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [RW-1:0] len,
	input  wire logic          deg_in,
	input  wire logic [MW-1:0] mag [tun_pkg::AXES],
	input  wire logic          neg_in [tun_pkg::AXES],
	output logic               vld,
	output logic               deg_out,
	output logic [QW-1:0]      quo [tun_pkg::AXES],
	output logic               neg_out [tun_pkg::AXES]
);
	localparam int DW = RW + 1;
	localparam int NW = MW + F + 3;

	logic [DW-1:0] den_s [QW+1];
	logic [NW-1:0] num_s [QW+1][tun_pkg::AXES];
	logic [DW:0]   rem_s [QW+1][tun_pkg::AXES];
	logic [QW-1:0] q_s   [QW+1][tun_pkg::AXES];
	logic          neg_s [QW+1][tun_pkg::AXES];
	logic          deg_s [QW+1];
	logic          vld_s [QW+1];
	logic [NW-1:0] num0  [tun_pkg::AXES];

	// numerator |X| * 2^(F+1) + L over 2L rounds half away from zero
	always_comb begin
		for (int k = 0; k < tun_pkg::AXES; k++) begin
			num0[k] = (NW'(mag[k]) << (F + 1)) + NW'(len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= {len, 1'b0};
			deg_s[0] <= deg_in;
			for (int k = 0; k < tun_pkg::AXES; k++) begin
				num_s[0][k] <= num0[k];
				rem_s[0][k] <= (DW+1)'(num0[k] >> QW);
				q_s[0][k]   <= '0;
				neg_s[0][k] <= neg_in[k];
			end
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int BIT = QW - 1 - i;
		logic [DW:0] cand [tun_pkg::AXES];
		logic        ge   [tun_pkg::AXES];

		always_comb begin
			for (int k = 0; k < tun_pkg::AXES; k++) begin
				cand[k] = {rem_s[i][k][DW-1:0], num_s[i][k][BIT]};
				ge[k]   = cand[k] >= (DW+1)'(den_s[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				deg_s[i+1] <= deg_s[i];
				for (int k = 0; k < tun_pkg::AXES; k++) begin
					num_s[i+1][k] <= num_s[i][k];
					rem_s[i+1][k] <= ge[k] ? cand[k] - (DW+1)'(den_s[i]) : cand[k];
					q_s[i+1][k]   <= {q_s[i][k][QW-2:0], ge[k]};
					neg_s[i+1][k] <= neg_s[i][k];
				end
			end
		end
	end

	assign vld     = vld_s[QW];
	assign deg_out = deg_s[QW];
	assign quo     = q_s[QW];
	assign neg_out = neg_s[QW];
endmodule
`default_nettype wire

>>> design/triangle_unit_normal.sv
// Triangle unit normal: top level. Uses tun_pkg, tun_cross, tun_square,
// tun_isqrt, tun_div and the assertion macros header.
//
// Takes one triangle per cycle and returns its unit face normal in
// Q1.NORMAL_FRAC_BITS plus a degenerate flag, in order. The pipe depth is
// set by the square root pipeline (one root bit per stage) and the divider
// lanes (one quotient bit per stage). Throughput is one word per cycle; the
// whole pipe holds when the output word is not taken, so in_ready follows
// out_ready whenever the output register is full. min_length is written
// through cfg_we and should change only while the pipe is empty.
`default_nettype none
`include "triangle_unit_normal_macros.svh"
module triangle_unit_normal #(
	parameter int COORD_WIDTH      = 24,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tun_pkg::MINLEN_W-1:0]  cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] ax,
	input  wire logic signed [COORD_WIDTH-1:0] ay,
	input  wire logic signed [COORD_WIDTH-1:0] az,
	input  wire logic signed [COORD_WIDTH-1:0] bx,
	input  wire logic signed [COORD_WIDTH-1:0] by,
	input  wire logic signed [COORD_WIDTH-1:0] bz,
	input  wire logic signed [COORD_WIDTH-1:0] cx,
	input  wire logic signed [COORD_WIDTH-1:0] cy,
	input  wire logic signed [COORD_WIDTH-1:0] cz,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [tun_pkg::OUT_W-1:0]   nx,
	output logic signed [tun_pkg::OUT_W-1:0]   ny,
	output logic signed [tun_pkg::OUT_W-1:0]   nz,
	output logic                               degenerate
);
	localparam int EW   = COORD_WIDTH + 1;
	localparam int MW   = 2 * EW;
	localparam int SW   = 2 * MW + 2;
	localparam int RW   = SW / 2;
	localparam int QW   = NORMAL_FRAC_BITS + 1;
	localparam int SBW  = 3 * MW + 3;
	localparam int CMPW = (RW > tun_pkg::MINLEN_W) ? RW : tun_pkg::MINLEN_W;
	localparam int OW   = (QW + 1 > tun_pkg::OUT_W) ? QW + 1 : tun_pkg::OUT_W;

	logic [tun_pkg::MINLEN_W-1:0] min_len_q;
	logic                         en;

	logic signed [COORD_WIDTH-1:0] a [tun_pkg::AXES];
	logic signed [COORD_WIDTH-1:0] b [tun_pkg::AXES];
	logic signed [COORD_WIDTH-1:0] c [tun_pkg::AXES];

	logic            x_vld;
	logic [MW-1:0]   x_mag [tun_pkg::AXES];
	logic            x_neg [tun_pkg::AXES];
	logic [SBW-1:0]  x_side;

	logic            sq_vld;
	logic [SW-1:0]   sq_sum;
	logic [SBW-1:0]  sq_side;

	logic            rt_vld;
	logic [RW-1:0]   rt_root;
	logic [SBW-1:0]  rt_side;

	logic            cmp_vld_s1;
	logic            cmp_deg_s1;
	logic [RW-1:0]   cmp_len_s1;
	logic [SBW-1:0]  cmp_side_s1;
	logic [MW-1:0]   cmp_mag [tun_pkg::AXES];
	logic            cmp_neg [tun_pkg::AXES];

	logic            dv_vld;
	logic            dv_deg;
	logic [QW-1:0]   dv_quo [tun_pkg::AXES];
	logic            dv_neg [tun_pkg::AXES];
	logic [OW-1:0]   sgn    [tun_pkg::AXES];

	logic                       out_vld_q;
	logic                       out_deg_q;
	logic [tun_pkg::OUT_W-1:0]  out_n_q [tun_pkg::AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= '0;
		end else if (cfg_we) begin
			min_len_q <= cfg_wdata;
		end
	end

	// advance the whole pipe unless a finished word is waiting and not taken
	assign en       = !out_vld_q || out_ready;
	assign in_ready = en;

	assign a[0] = ax;
	assign a[1] = ay;
	assign a[2] = az;
	assign b[0] = bx;
	assign b[1] = by;
	assign b[2] = bz;
	assign c[0] = cx;
	assign c[1] = cy;
	assign c[2] = cz;

	tun_cross #(.CW(COORD_WIDTH)) u_cross (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (in_valid),
		.a      (a),
		.b      (b),
		.c      (c),
		.vld    (x_vld),
		.mag    (x_mag),
		.neg    (x_neg)
	);

	assign x_side = {x_neg[2], x_neg[1], x_neg[0], x_mag[2], x_mag[1], x_mag[0]};

	tun_square #(.MW(MW), .SBW(SBW)) u_square (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (x_vld),
		.mag      (x_mag),
		.side_in  (x_side),
		.vld      (sq_vld),
		.sum      (sq_sum),
		.side_out (sq_side)
	);

	tun_isqrt #(.SW(SW), .SBW(SBW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.rad      (sq_sum),
		.side_in  (sq_side),
		.vld      (rt_vld),
		.root     (rt_root),
		.side_out (rt_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else if (en) begin
			cmp_vld_s1 <= rt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmp_deg_s1  <= CMPW'(rt_root) <= CMPW'(min_len_q);
			cmp_len_s1  <= rt_root;
			cmp_side_s1 <= rt_side;
		end
	end

	always_comb begin
		for (int k = 0; k < tun_pkg::AXES; k++) begin
			cmp_mag[k] = cmp_side_s1[k*MW +: MW];
			cmp_neg[k] = cmp_side_s1[3*MW + k];
		end
	end

	tun_div #(.MW(MW), .RW(RW), .F(NORMAL_FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (cmp_vld_s1),
		.len     (cmp_len_s1),
		.deg_in  (cmp_deg_s1),
		.mag     (cmp_mag),
		.neg_in  (cmp_neg),
		.vld     (dv_vld),
		.deg_out (dv_deg),
		.quo     (dv_quo),
		.neg_out (dv_neg)
	);

	always_comb begin
		for (int k = 0; k < tun_pkg::AXES; k++) begin
			sgn[k] = dv_neg[k] ? -OW'(dv_quo[k]) : OW'(dv_quo[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_deg_q <= dv_deg;
			for (int k = 0; k < tun_pkg::AXES; k++) begin
				// drop the quotient of a degenerate triangle
				out_n_q[k] <= dv_deg ? '0 : sgn[k][tun_pkg::OUT_W-1:0];
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign degenerate = out_deg_q;
	assign nx         = out_n_q[0];
	assign ny         = out_n_q[1];
	assign nz         = out_n_q[2];

	`TUN_ASSERT_NOW(a_deg_zero, out_valid && degenerate, nx == 0 && ny == 0 && nz == 0, "degenerate word carries a nonzero normal")
	`TUN_ASSERT_NOW(a_live_nonzero, out_valid && !degenerate, nx != 0 || ny != 0 || nz != 0, "normal of a live triangle is all zero")
	`TUN_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "pipe refuses input with an empty output register")
endmodule
`default_nettype wire
